@@ design/tccs_pkg.sv @@
// ----------------------------------------------------------------------------
// tccs_pkg: shared types and constants for the text console
// Payload structs, action codes, datapath commands and status.
// ----------------------------------------------------------------------------
package tccs_pkg;

    // Character codes and reset attribute
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] RETURN_CODE  = 8'd13;
    localparam logic [7:0] BLANK_CODE   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    // Request actions
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_BACK  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    // Input request payload
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    // Result payload
    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } out_item_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_PUT_CHAR  = 4'd2,
        OP_BACK      = 4'd3,
        OP_HOME      = 4'd4,
        OP_CELL_RD   = 4'd5,
        OP_CELL_CAP  = 4'd6,
        OP_SCR_RD    = 4'd7,
        OP_SCR_WR    = 4'd8,
        OP_FILL      = 4'd9,
        OP_INIT_FILL = 4'd10
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   res_load;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    wrap;
        logic    sw_col_last;
        logic    sw_row_last;
        logic    sw_row_copy_last;
        logic    out_free;
    } stat_t;

endpackage

@@ design/tccs_ram.sv @@
// ----------------------------------------------------------------------------
// tccs_ram: generic single write port, single read port RAM
// Read data is registered and appears the cycle after the read enable.
// ----------------------------------------------------------------------------
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/tccs_ctrl.sv @@
// ----------------------------------------------------------------------------
// tccs_ctrl: sequencing state machine for the text console
// Takes requests, steps the datapath through each action and hands results on.
// ----------------------------------------------------------------------------
module tccs_ctrl
    import tccs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_EXEC   = 8'b0000_0100,
        ST_RD_WT  = 8'b0000_1000,
        ST_SCR_RD = 8'b0001_0000,
        ST_SCR_WR = 8'b0010_0000,
        ST_FILL   = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Hold state, clear the screen store after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.res_load = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.op = OP_INIT_FILL;
                if (stat.sw_col_last && stat.sw_row_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (stat.action)
                    ACT_WRITE: begin
                        cmd.op     = OP_PUT_CHAR;
                        state_next = stat.wrap ? ST_SCR_RD : ST_FINISH;
                    end
                    ACT_BACK: begin
                        cmd.op     = OP_BACK;
                        state_next = ST_FINISH;
                    end
                    ACT_CLEAR: begin
                        cmd.op     = OP_HOME;
                        state_next = ST_FILL;
                    end
                    default: begin
                        cmd.op     = OP_CELL_RD;
                        state_next = ST_RD_WT;
                    end
                endcase
            end
            ST_RD_WT: begin
                cmd.op     = OP_CELL_CAP;
                state_next = ST_FINISH;
            end
            ST_SCR_RD: begin
                cmd.op     = OP_SCR_RD;
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                cmd.op = OP_SCR_WR;
                if (stat.sw_col_last && stat.sw_row_copy_last) begin
                    state_next = ST_FILL;
                end else begin
                    state_next = ST_SCR_RD;
                end
            end
            ST_FILL: begin
                cmd.op = OP_FILL;
                if (stat.sw_col_last && stat.sw_row_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/tccs_dp.sv @@
// ----------------------------------------------------------------------------
// tccs_dp: datapath for the text console
// Cursor, attribute, sweep counters, screen store and result register.
// ----------------------------------------------------------------------------
module tccs_dp
    import tccs_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  cmd_t      cmd,
    output stat_t     stat
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH = ROWS << COL_W;
    localparam logic [COL_W:0]   COL_LIMIT = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0] ROW_COPY  = ROW_W'(ROWS - 2);

    in_item_t         req_reg;
    logic [7:0]       attr_reg;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] sw_col_reg, sw_col_next;
    logic [ROW_W-1:0] sw_row_reg, sw_row_next;
    logic             scroll_reg, scroll_next;
    logic [15:0]      cell_reg, cell_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        out_reg;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata, mem_rdata;

    logic [COL_W:0]    col_inc;
    logic              is_nl, is_cr, is_plain;
    logic              row_bump, wrap;
    logic [COL_W-1:0]  put_col;
    logic              sw_col_last, sw_row_last;
    logic [ROW_W+4:0]  rd_row_ext;
    logic [COL_W+6:0]  rd_col_ext;
    logic              rd_ok;
    logic [COL_W+6:0]  out_col_ext;
    logic [ROW_W+4:0]  out_row_ext;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // Cursor movement for a written byte
    always_comb begin
        col_inc  = {1'b0, cur_col_reg} + 1'b1;
        is_nl    = (req_reg.char_code == NEWLINE_CODE);
        is_cr    = (req_reg.char_code == RETURN_CODE);
        is_plain = !is_nl && !is_cr;
        if (is_nl) begin
            put_col  = '0;
            row_bump = 1'b1;
        end else if (is_cr) begin
            put_col  = '0;
            row_bump = 1'b0;
        end else if (col_inc == COL_LIMIT) begin
            put_col  = '0;
            row_bump = 1'b1;
        end else begin
            put_col  = col_inc[COL_W-1:0];
            row_bump = 1'b0;
        end
        wrap = row_bump && (cur_row_reg == ROW_LAST);
    end

    // Read address range check
    always_comb begin
        rd_row_ext = {{ROW_W{1'b0}}, req_reg.read_row};
        rd_col_ext = {{COL_W{1'b0}}, req_reg.read_col};
        rd_ok      = (rd_row_ext < (ROW_W + 5)'(ROWS)) && (rd_col_ext < (COL_W + 7)'(COLUMNS));
    end

    assign sw_col_last = (sw_col_reg == COL_LAST);
    assign sw_row_last = (sw_row_reg == ROW_LAST);

    // Status to the controller
    always_comb begin
        stat.action           = action_t'(req_reg.action);
        stat.wrap             = wrap;
        stat.sw_col_last      = sw_col_last;
        stat.sw_row_last      = sw_row_last;
        stat.sw_row_copy_last = (sw_row_reg == ROW_COPY);
        stat.out_free         = !m_valid_reg || m_ready;
    end

    // Store port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = {sw_row_reg, sw_col_reg};
        mem_raddr = {sw_row_reg + 1'b1, sw_col_reg};
        mem_wdata = {attr_reg, BLANK_CODE};
        case (cmd.op)
            OP_PUT_CHAR: begin
                mem_we    = is_plain;
                mem_waddr = {cur_row_reg, cur_col_reg};
                mem_wdata = {attr_reg, req_reg.char_code};
            end
            OP_BACK: begin
                mem_we    = (cur_col_reg != '0);
                mem_waddr = {cur_row_reg, cur_col_reg - 1'b1};
            end
            OP_CELL_RD: begin
                mem_re    = rd_ok;
                mem_raddr = {rd_row_ext[ROW_W-1:0], rd_col_ext[COL_W-1:0]};
            end
            OP_SCR_RD: begin
                mem_re = 1'b1;
            end
            OP_SCR_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
            end
            OP_FILL: begin
                mem_we = 1'b1;
            end
            OP_INIT_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, BLANK_CODE};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Cursor, sweep and capture updates
    always_comb begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        sw_col_next  = sw_col_reg;
        sw_row_next  = sw_row_reg;
        scroll_next  = scroll_reg;
        cell_next    = cell_reg;
        case (cmd.op)
            OP_LOAD: begin
                scroll_next = 1'b0;
                cell_next   = '0;
            end
            OP_PUT_CHAR: begin
                cur_col_next = put_col;
                scroll_next  = wrap;
                if (row_bump && !wrap) begin
                    cur_row_next = cur_row_reg + 1'b1;
                end
            end
            OP_BACK: begin
                if (cur_col_reg != '0) begin
                    cur_col_next = cur_col_reg - 1'b1;
                end
            end
            OP_HOME: begin
                cur_col_next = '0;
                cur_row_next = '0;
            end
            OP_CELL_CAP: begin
                cell_next = rd_ok ? mem_rdata : 16'd0;
            end
            default: begin
                cell_next = cell_reg;
            end
        endcase
        // Advance the sweep, wrapping to the origin after the last cell
        if (cmd.op == OP_SCR_WR || cmd.op == OP_FILL || cmd.op == OP_INIT_FILL) begin
            if (sw_col_last) begin
                sw_col_next = '0;
                sw_row_next = sw_row_last ? '0 : sw_row_reg + 1'b1;
            end else begin
                sw_col_next = sw_col_reg + 1'b1;
            end
        end
    end

    // Result valid: set on load, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign out_col_ext = {7'd0, cur_col_reg};
    assign out_row_ext = {5'd0, cur_row_reg};

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg    <= RESET_ATTR;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            sw_col_reg  <= '0;
            sw_row_reg  <= '0;
            scroll_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                attr_reg <= cfg_data;
            end
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            sw_col_reg  <= sw_col_next;
            sw_row_reg  <= sw_row_next;
            scroll_reg  <= scroll_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
        if (cmd.op == OP_LOAD) begin
            req_reg <= s_data;
        end
        if (cmd.res_load) begin
            out_reg.cursor_col <= out_col_ext[6:0];
            out_reg.cursor_row <= out_row_ext[4:0];
            out_reg.scrolled   <= scroll_reg;
            out_reg.cell_char  <= cell_reg[7:0];
            out_reg.cell_attr  <= cell_reg[15:8];
        end
    end

    tccs_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_screen (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

@@ design/text_console_cursor_scroll_top.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top: text-mode teletype with screen store
// Cursor-driven character console with wrap, scroll, backspace, clear, read.
// ----------------------------------------------------------------------------
// Requests enter on s_valid/s_ready with an in_item_t payload; every request
// gives exactly one out_item_t result on m_valid/m_ready. The attribute byte
// is written through cfg_valid/cfg_ready/cfg_data (always ready, takes effect
// for the following requests).
// Requests are processed one at a time, from acceptance to result valid. A clear
// blanks all ROWS*COLUMNS cells; a write that scrolls moves rows 1 to ROWS-1 up
// by one and blanks the bottom row.
// The screen store has one write port and one read port: a scroll copies each
// cell with a read step and then a write step, and fills blank one cell a
// cycle. A new request is taken once the previous one has finished.
// After reset the store is blanked (space, attribute 7) cell by cell, while
// s_ready stays low; configuration writes are still taken.
// A stalled receiver holds the result in the output register; the next request
// may still be accepted and processed, and waits only to deliver its result.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top
    import tccs_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    tccs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tccs_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
